// ----- hw/rtl/bhso_pkg.sv -----
// shared constants, command codes and control structs for the byte histogram
// used by bhso_ctrl, bhso_datapath and byte_histogram_sorted_order
package bhso_pkg;

	// bin storage sizing
	localparam int SYMBOLS     = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int SYM_W       = $clog2(SYMBOLS);
	localparam int REPORT_W    = 32;
	localparam int EXT_W       = (COUNT_WIDTH > REPORT_W) ? COUNT_WIDTH : REPORT_W;

	// command codes on the input channel
	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_NEXT    = 3'd1;
	localparam logic [2:0] CMD_RESTART = 3'd2;
	localparam logic [2:0] CMD_READ    = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic rd_en;
		logic rd_scan;
		logic wr_en;
		logic scan_start;
		logic scan_step;
		logic load_out;
		logic out_next;
		logic restart;
		logic clear;
	} bhso_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} bhso_sts_t;

	// clamp a bin count to the reported width
	function automatic logic [REPORT_W-1:0] report_count(input logic [COUNT_WIDTH-1:0] c);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(c);
		if (ext > EXT_W'({REPORT_W{1'b1}}))
			return '1;
		else
			return ext[REPORT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/bhso_ctrl.sv -----
// controller state machine: sequences add, read, scan and result hand-off
// depends on bhso_pkg
module bhso_ctrl
	import bhso_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  bhso_sts_t  sts,
	output bhso_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0] state_q, state_d;
	logic       next_q, next_d;

	// next-state and command decode
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		next_d   = next_q;
		in_ready = 1'b0;
		cmd.out_next = next_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					case (command)
						CMD_ADD: begin
							cmd.rd_en = 1'b1;
							state_d   = ST_ADD;
						end
						CMD_READ: begin
							cmd.rd_en = 1'b1;
							next_d    = 1'b0;
							state_d   = ST_RESULT;
						end
						CMD_NEXT: begin
							cmd.scan_start = 1'b1;
							next_d         = 1'b1;
							state_d        = ST_SCAN;
						end
						CMD_RESTART: cmd.restart = 1'b1;
						CMD_CLEAR:   cmd.clear   = 1'b1;
						default: ;
					endcase
				end
			end
			ST_ADD: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_scan   = 1'b1;
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_d = ST_DRAIN;
			end
			// last bin compares in this cycle
			ST_DRAIN: state_d = ST_RESULT;
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			next_q  <= next_d;
		end
	end

endmodule

// ----- hw/rtl/bhso_datapath.sv -----
// datapath: bin memory with valid bits, scan compare, cursor and output register
// depends on bhso_pkg
module bhso_datapath
	import bhso_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_value,
	input  bhso_cmd_t           cmd,
	output bhso_sts_t           sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          symbol,
	output logic [REPORT_W-1:0] count,
	output logic                found
);

	logic [COUNT_WIDTH-1:0] mem [SYMBOLS];
	logic [SYMBOLS-1:0]     valid_q;

	logic [COUNT_WIDTH-1:0] rd_data_s1;
	logic                   rd_valid_s1;
	logic [SYM_W-1:0]       rd_idx_s1;
	logic                   cmp_v_s1;

	logic [7:0]             byte_q;
	logic                   in_range_q;
	logic [SYM_W-1:0]       scan_q;
	logic                   have_q;
	logic [COUNT_WIDTH-1:0] best_c_q;
	logic [SYM_W-1:0]       best_s_q;
	logic [COUNT_WIDTH-1:0] cur_c_q;
	logic [SYM_W-1:0]       cur_s_q;
	logic                   started_q;

	logic                   out_valid_q;
	logic [7:0]             sym_q;
	logic [REPORT_W-1:0]    cnt_q;
	logic                   found_q;

	logic [SYM_W-1:0]       rd_addr;
	logic [SYM_W-1:0]       wr_addr;
	logic [COUNT_WIDTH-1:0] cur_bin;
	logic [COUNT_WIDTH-1:0] inc_bin;
	logic                   above;
	logic                   better;
	logic                   take;
	logic                   in_range;

	// address select and bin value seen on the read port
	assign in_range = ({1'b0, byte_value} < 9'(SYMBOLS));
	assign rd_addr  = cmd.rd_scan ? scan_q : byte_value[SYM_W-1:0];
	assign wr_addr  = byte_q[SYM_W-1:0];
	assign cur_bin  = rd_valid_s1 ? rd_data_s1 : '0;
	assign inc_bin  = (cur_bin == '1) ? cur_bin : cur_bin + COUNT_WIDTH'(1);

	// ordering tests for the scan: strictly above the cursor, below the best so far
	assign above  = !started_q || (cur_bin > cur_c_q) ||
	                ((cur_bin == cur_c_q) && (rd_idx_s1 > cur_s_q));
	assign better = !have_q || (cur_bin < best_c_q);
	assign take   = cmp_v_s1 && (cur_bin != '0) && above && better;

	assign sts.scan_last = (scan_q == SYM_W'(SYMBOLS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// bin memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && in_range_q)
			mem[wr_addr] <= inc_bin;
		if (cmd.rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	// valid bits and read-side pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			cmp_v_s1    <= 1'b0;
		end else begin
			if (cmd.clear)
				valid_q <= '0;
			else if (cmd.wr_en && in_range_q)
				valid_q[wr_addr] <= 1'b1;
			if (cmd.rd_en)
				rd_valid_s1 <= valid_q[rd_addr];
			cmp_v_s1 <= cmd.rd_en && cmd.rd_scan;
		end
	end

	// payload captures: input byte, read index
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			byte_q     <= byte_value;
			in_range_q <= in_range;
		end
		if (cmd.rd_en)
			rd_idx_s1 <= rd_addr;
	end

	// scan counter and best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			have_q   <= 1'b0;
			best_c_q <= '0;
			best_s_q <= '0;
		end else begin
			if (cmd.scan_start)
				scan_q <= '0;
			else if (cmd.scan_step)
				scan_q <= scan_q + SYM_W'(1);
			if (cmd.scan_start)
				have_q <= 1'b0;
			else if (take) begin
				have_q   <= 1'b1;
				best_c_q <= cur_bin;
				best_s_q <= rd_idx_s1;
			end
		end
	end

	// walk cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_c_q   <= '0;
			cur_s_q   <= '0;
			started_q <= 1'b0;
		end else if (cmd.clear) begin
			cur_c_q   <= '0;
			cur_s_q   <= '0;
			started_q <= 1'b0;
		end else if (cmd.restart) begin
			started_q <= 1'b0;
		end else if (cmd.load_out && cmd.out_next && have_q) begin
			cur_c_q   <= best_c_q;
			cur_s_q   <= best_s_q;
			started_q <= 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.out_next) begin
				sym_q   <= have_q ? 8'(best_s_q) : 8'd0;
				cnt_q   <= have_q ? report_count(best_c_q) : '0;
				found_q <= have_q;
			end else begin
				sym_q   <= byte_q;
				cnt_q   <= in_range_q ? report_count(cur_bin) : '0;
				found_q <= in_range_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = sym_q;
	assign count     = cnt_q;
	assign found     = found_q;

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transaction");

	// bin write and read never share a cycle
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !cmd.rd_en)
		else $error("bin write and read in the same cycle");

	// a candidate always has a nonzero count
	a_best_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (best_c_q != '0))
		else $error("scan candidate with zero count");

	// handing out an entry starts the walk
	a_cursor_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && cmd.out_next && have_q && !cmd.clear && !cmd.restart) |=> started_q)
		else $error("cursor not started after an entry was given");

endmodule

// ----- hw/rtl/byte_histogram_sorted_order.sv -----
// byte histogram with ascending (count, symbol) walk over nonzero bins
// add byte: bin read, then saturating write back; read bin: bin read, then result load
// next in order: one bin per cycle through the single memory read port
// restart, clear and unused codes finish in the idle state; the result register lets an add proceed
// while a result waits; reset clears every bin valid bit, the cursor and the output at once
// depends on bhso_pkg, bhso_ctrl, bhso_datapath
module byte_histogram_sorted_order
	import bhso_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          command,
	input  logic [7:0]          byte_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          symbol,
	output logic [REPORT_W-1:0] count,
	output logic                found
);

	bhso_cmd_t cmd;
	bhso_sts_t sts;

	// sequencer
	bhso_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bins, scan and output register
	bhso_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.count      (count),
		.found      (found)
	);

endmodule

// ----- tb/histogram_order_checker.sv -----
// transaction checker for byte_histogram_sorted_order: keeps its own bin counts and walk cursor
// and compares every result transaction against the oldest predicted answer
// depends on bhso_pkg for the command codes and the bin and report widths
module histogram_order_checker
	import bhso_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [2:0]          command,
	input  logic [7:0]          byte_value,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [7:0]          symbol,
	input  logic [REPORT_W-1:0] count,
	input  logic                found,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]          symbol;
		logic [REPORT_W-1:0] count;
		logic                found;
	} answer_t;

	// predicted histogram and walk position
	logic [COUNT_WIDTH-1:0] bin_tally [SYMBOLS];
	logic [COUNT_WIDTH-1:0] walk_count;
	int                     walk_symbol;
	logic                   walk_active;
	answer_t                answers_due [$];

	// counts wider than the report saturate at all ones
	function automatic logic [REPORT_W-1:0] clamp_report(input logic [COUNT_WIDTH-1:0] c);
		if (c > COUNT_WIDTH'({REPORT_W{1'b1}}))
			return '1;
		return REPORT_W'(c);
	endfunction

	task automatic clear_histogram();
		for (int s = 0; s < SYMBOLS; s++)
			bin_tally[s] = '0;
		walk_count  = '0;
		walk_symbol = 0;
		walk_active = 1'b0;
	endtask

	// update the prediction for one accepted command transaction
	task automatic apply_transaction(input logic [2:0] cmd, input logic [7:0] val);
		answer_t                ans;
		logic                   hit;
		logic                   eligible;
		logic [COUNT_WIDTH-1:0] best_c;
		int                     best_s;
		ans    = '0;
		hit    = 1'b0;
		best_c = '0;
		best_s = 0;
		case (cmd)
			CMD_ADD: begin
				// bins stop at their maximum
				if (int'(val) < SYMBOLS && bin_tally[val] != '1)
					bin_tally[val] = bin_tally[val] + 1'b1;
			end
			CMD_RESTART: begin
				walk_active = 1'b0;
			end
			CMD_CLEAR: begin
				clear_histogram();
			end
			CMD_READ: begin
				ans.symbol = val;
				if (int'(val) < SYMBOLS) begin
					ans.count = clamp_report(bin_tally[val]);
					ans.found = 1'b1;
				end
				answers_due.push_back(ans);
			end
			CMD_NEXT: begin
				// smallest nonzero (count, symbol) strictly past the cursor
				for (int s = 0; s < SYMBOLS; s++) begin
					eligible = (bin_tally[s] != '0);
					if (eligible && walk_active)
						eligible = (bin_tally[s] > walk_count) ||
							(bin_tally[s] == walk_count && s > walk_symbol);
					// ascending scan keeps the lower symbol on equal counts
					if (eligible && (!hit || bin_tally[s] < best_c)) begin
						hit    = 1'b1;
						best_c = bin_tally[s];
						best_s = s;
					end
				end
				if (hit) begin
					walk_count  = best_c;
					walk_symbol = best_s;
					walk_active = 1'b1;
					ans.symbol  = 8'(best_s);
					ans.count   = clamp_report(best_c);
					ans.found   = 1'b1;
				end
				answers_due.push_back(ans);
			end
			default: begin
				// unused codes change nothing
			end
		endcase
	endtask

	// compare one result transaction field by field
	task automatic check_answer();
		answer_t want;
		if (answers_due.size() == 0) begin
			$display("%0t: unexpected result symbol %0d count %0d found %0d",
				$time, symbol, count, found);
			errors++;
		end else begin
			want = answers_due.pop_front();
			if (symbol !== want.symbol) begin
				$display("%0t: symbol expected %0d actual %0d", $time, want.symbol, symbol);
				errors++;
			end
			if (count !== want.count) begin
				$display("%0t: count expected %0d actual %0d", $time, want.count, count);
				errors++;
			end
			if (found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, found);
				errors++;
			end
		end
	endtask

	// predict on accepted commands, then check accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_histogram();
			answers_due.delete();
			errors = 0;
		end else begin
			if (in_valid && in_ready)
				apply_transaction(command, byte_value);
			if (out_valid && out_ready)
				check_answer();
		end
		pending = answers_due.size();
	end

endmodule

// ----- tb/tb.sv -----
// top of the byte_histogram_sorted_order testbench: clock, reset, command stimulus and verdict
// depends on bhso_pkg, byte_histogram_sorted_order and histogram_order_checker
module tb
	import bhso_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// first code past the defined commands
	localparam logic [2:0] CMD_SPARE = CMD_CLEAR + 3'd1;
	localparam int         ITEM_GOAL = 1100;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic [2:0]          command    = CMD_ADD;
	logic [7:0]          byte_value = 8'h00;
	logic                out_ready  = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic [7:0]          symbol;
	logic [REPORT_W-1:0] count;
	logic                found;

	int send_idle  = 7;
	int recv_idle  = 55;
	int items_sent = 0;
	int fail_count;
	int open_answers;

	byte_histogram_sorted_order dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.count      (count),
		.found      (found)
	);

	histogram_order_checker u_order_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.count      (count),
		.found      (found),
		.errors     (fail_count),
		.pending    (open_answers)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// one command transaction, with random idle cycles ahead of it
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] val);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		byte_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (cmd <= CMD_CLEAR)
			items_sent++;
	endtask

	// mostly bytes from a narrow window so walks run to the end, with some strays
	function automatic logic [7:0] near_byte(input logic [7:0] base, input int span);
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		return base + 8'($urandom_range(0, span));
	endfunction

	// fill some bins, then walk the order with counting, reads and junk mixed in
	task automatic run_round();
		logic [7:0] base;
		int         span;
		int         n_add;
		int         n_next;
		base   = 8'($urandom);
		span   = $urandom_range(0, 10);
		n_add  = $urandom_range(3, 20);
		n_next = $urandom_range(2, 14);
		if ($urandom_range(0, 2) == 0)
			send_item(CMD_CLEAR, 8'($urandom));
		repeat (n_add) begin
			send_item(CMD_ADD, near_byte(base, span));
			if ($urandom_range(0, 7) == 0)
				send_item(CMD_READ, near_byte(base, span));
		end
		if ($urandom_range(0, 9) != 0)
			send_item(CMD_RESTART, 8'($urandom));
		repeat (n_next) begin
			case ($urandom_range(0, 19))
				0, 1, 2: send_item(CMD_ADD, near_byte(base, span));
				3, 4:    send_item(CMD_READ, 8'($urandom));
				5:       send_item(CMD_SPARE + 3'($urandom_range(0, 2)), 8'($urandom));
				default: ;
			endcase
			send_item(CMD_NEXT, 8'($urandom));
		end
		// unstructured noise
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4))
				send_item(3'($urandom), 8'($urandom));
	endtask

	// stimulus and verdict
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme bytes, ties and the start of a walk
		send_item(CMD_ADD, 8'h00);
		send_item(CMD_ADD, 8'hFF);
		send_item(CMD_ADD, 8'hFF);
		send_item(CMD_ADD, 8'h80);
		send_item(CMD_ADD, 8'h55);
		send_item(CMD_ADD, 8'hAA);
		send_item(CMD_READ, 8'hFF);
		send_item(CMD_READ, 8'h01);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_NEXT, 8'hFF);
		// counting during a walk moves a bin past the cursor; the walk then runs to exhaustion and past it
		send_item(CMD_ADD, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_NEXT, 8'hFF);
		// restart, unused codes, clear, then an empty walk
		send_item(CMD_RESTART, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_SPARE, 8'hFF);
		send_item(CMD_SPARE + 3'd1, 8'h00);
		send_item(CMD_SPARE + 3'd2, 8'hFF);
		send_item(CMD_CLEAR, 8'h00);
		send_item(CMD_NEXT, 8'h00);
		send_item(CMD_READ, 8'hFF);

		// random rounds under three idle patterns
		while (items_sent < ITEM_GOAL) begin
			if (items_sent < ITEM_GOAL / 3) begin
				send_idle = 7;
				recv_idle = 55;
			end else if (items_sent < 2 * ITEM_GOAL / 3) begin
				send_idle = 55;
				recv_idle = 7;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			run_round();
		end
		in_valid <= 1'b0;

		// drain, then allow one full scan for anything stray
		do @(negedge clk); while (open_answers != 0);
		repeat (SYMBOLS + 16) @(posedge clk);
		if (fail_count == 0 && open_answers == 0)
			$display("byte_histogram_sorted_order test passed");
		else
			$display("byte_histogram_sorted_order test failed");
		$finish;
	end

	// hang guard
	initial begin
		#15_000_000;
		$display("byte_histogram_sorted_order test failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bhso_pkg.sv
hw/rtl/bhso_ctrl.sv
hw/rtl/bhso_datapath.sv
hw/rtl/byte_histogram_sorted_order.sv
tb/histogram_order_checker.sv
tb/tb.sv
